[rtl/pevc_pkg.sv]
package pevc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PAL_DEPTH  = 256;
   localparam int PAL_AW     = 8;
   localparam int RGB_W      = 24;
   localparam int POS_W      = 11;
   localparam int SPAN_W     = 12;
   localparam int EDGE_W     = 13;
   localparam int ARGB_W     = 32;
   localparam int REQ_DATA_W = 104;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   localparam logic CMD_PAL_WRITE = 1'b0;
   localparam logic CMD_PIXEL     = 1'b1;

   localparam logic [2:0] CSR_COMPOSITE_ENABLE = 3'd0;
   localparam logic [2:0] CSR_VIEW_LEFT        = 3'd1;
   localparam logic [2:0] CSR_VIEW_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_VIEW_TOP         = 3'd3;
   localparam logic [2:0] CSR_VIEW_HEIGHT      = 3'd4;

   // request payload, first declared member sits in the top bits
   typedef struct packed {
      logic [1:0]       pad;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic [31:0]      truecolor_value;
      logic [7:0]       snapshot_code;
      logic [7:0]       pixel_code;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       entry_index;
   } req_data_type;

endpackage

[rtl/pevc_ram.sv]
module pevc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/palette_expand_view_composite_top.sv]
// Throughput: one request per cycle, palette writes and pixels alike, while the
// output is not stalled; a held result backs the pipeline up to req_tready.
// Palette read goes through a registered RAM port; an output register follows.
// Palette writes give no result. Reset is synchronous, active high: it clears
// the pipeline valids, the enable and view registers; palette contents are not cleared.
module palette_expand_view_composite_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, red, green, blue, pixel_code, snapshot_code,
   // truecolor_value, column, row, zero pad
   input  logic [pevc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // argb
   output logic [pevc_pkg::ARGB_W-1:0]       rsp_tdata,
   // used_truecolor
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pevc_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [pevc_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [pevc_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import pevc_pkg::*;

   req_data_type req;
   logic         req_fire;
   logic         pal_wr;
   logic         pix_rd;

   logic              enable_ff;
   logic [POS_W-1:0]  left_ff;
   logic [SPAN_W-1:0] width_ff;
   logic [POS_W-1:0]  top_ff;
   logic [SPAN_W-1:0] height_ff;

   logic              csr_wr;
   logic [2:0]        csr_idx;

   logic [EDGE_W-1:0] col_x;
   logic [EDGE_W-1:0] row_x;
   logic [EDGE_W-1:0] col_end;
   logic [EDGE_W-1:0] row_end;
   logic              in_cols;
   logic              in_rows;
   logic              take_tc;

   logic              s1_valid_ff;
   logic              s1_tc_sel_ff;
   logic [31:0]       s1_tc_ff;
   logic [RGB_W-1:0]  pal_rgb;
   logic              s1_advance;

   logic              rsp_valid_ff;
   logic [ARGB_W-1:0] rsp_argb_ff;
   logic              rsp_used_ff;
   logic [ARGB_W-1:0] rsp_argb_in;

   assign req        = req_data_type'(req_tdata);
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;
   assign pal_wr     = req_fire && (req_tuser == CMD_PAL_WRITE);
   assign pix_rd     = req_fire && (req_tuser == CMD_PIXEL);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         left_ff   <= '0;
         width_ff  <= '0;
         top_ff    <= '0;
         height_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_COMPOSITE_ENABLE: enable_ff <= csr_pwdata[0];
            CSR_VIEW_LEFT:        left_ff   <= csr_pwdata[POS_W-1:0];
            CSR_VIEW_WIDTH:       width_ff  <= csr_pwdata[SPAN_W-1:0];
            CSR_VIEW_TOP:         top_ff    <= csr_pwdata[POS_W-1:0];
            CSR_VIEW_HEIGHT:      height_ff <= csr_pwdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_COMPOSITE_ENABLE: csr_prdata = {{(CSR_DW-1){1'b0}}, enable_ff};
         CSR_VIEW_LEFT:        csr_prdata = {{(CSR_DW-POS_W){1'b0}}, left_ff};
         CSR_VIEW_WIDTH:       csr_prdata = {{(CSR_DW-SPAN_W){1'b0}}, width_ff};
         CSR_VIEW_TOP:         csr_prdata = {{(CSR_DW-POS_W){1'b0}}, top_ff};
         CSR_VIEW_HEIGHT:      csr_prdata = {{(CSR_DW-SPAN_W){1'b0}}, height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // view rectangle test, edges summed one bit wider so they never wrap
   always_comb begin
      col_x   = {2'b00, req.column};
      row_x   = {2'b00, req.row};
      col_end = {2'b00, left_ff} + {1'b0, width_ff};
      row_end = {2'b00, top_ff} + {1'b0, height_ff};
      in_cols = (col_x >= {2'b00, left_ff}) && (col_x < col_end)
                && (col_x < EDGE_W'(MAX_WIDTH));
      in_rows = (row_x >= {2'b00, top_ff}) && (row_x < row_end)
                && (row_x < EDGE_W'(MAX_HEIGHT));
      take_tc = enable_ff && in_cols && in_rows
                && (req.pixel_code == req.snapshot_code);
   end

   pevc_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock      (clock),
      .wr_en      (pal_wr),
      .wr_addr    (req.entry_index),
      .wr_data    ({req.red, req.green, req.blue}),
      .rd_en      (pix_rd),
      .rd_addr    (req.pixel_code),
      .rd_data_ff (pal_rgb)
   );

   // stage 1: palette read in flight; RAM output holds while this stage stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pix_rd) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_rd) begin
         s1_tc_sel_ff <= take_tc;
         s1_tc_ff     <= req.truecolor_value;
      end
   end

   assign rsp_argb_in = s1_tc_sel_ff ? s1_tc_ff : {ALPHA_OPAQUE, pal_rgb};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_argb_ff <= rsp_argb_in;
         rsp_used_ff <= s1_tc_sel_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_argb_ff;
   assign rsp_tuser  = rsp_used_ff;

endmodule

[rtl/pevc_checker.sv]
module pevc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pevc_pkg::ARGB_W-1:0]     rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_pready
);
   import pevc_pkg::*;

   // palette-sourced pixels are always opaque
   a_palette_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 1'b0) |-> rsp_tdata[31:24] == ALPHA_OPAQUE)
      else $error("palette result without opaque alpha");

   // with the pipe idle beforehand, a palette write alone never produces a result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !req_tvalid
      ##1 !rsp_tvalid && !req_tvalid
      ##1 (req_tvalid && req_tready && (req_tuser == CMD_PAL_WRITE))
      ##1 !req_tvalid
      |=> !rsp_tvalid)
      else $error("result appeared for a palette write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready dropped");

endmodule

bind palette_expand_view_composite_top pevc_checker u_pevc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
